// ----- rtl/proximity_zone_debouncer_defines.svh -----
// Assertion macros for the proximity zone debouncer.
`ifndef PROXIMITY_ZONE_DEBOUNCER_DEFINES_SVH
`define PROXIMITY_ZONE_DEBOUNCER_DEFINES_SVH

`ifndef SYNTHESIS

`define PZD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define PZD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PZD_ASSERT_SAME(label, ante, cons, msg)

`define PZD_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ----- rtl/pzd_pkg.sv -----
// Shared types and constants of the proximity zone debouncer.
package pzd_pkg;

    localparam int LEVEL_BITS = 23;
    localparam int RUN_BITS   = 8;
    localparam int TIME_BITS  = 32;
    localparam int CFG_IDX_BITS = 3;

    typedef enum logic [1:0] {
        ZONE_FAR     = 2'd0,
        ZONE_MEDIUM  = 2'd1,
        ZONE_NEAR    = 2'd2,
        ZONE_CONTACT = 2'd3
    } zone_t;

    localparam logic [CFG_IDX_BITS-1:0] CFG_FAR_LEVEL      = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MEDIUM_LEVEL   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NEAR_LEVEL     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEBOUNCE_COUNT = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SAR_ENABLE     = 3'd4;

    localparam logic [LEVEL_BITS-1:0] FAR_LEVEL_RST      = 23'd50;
    localparam logic [LEVEL_BITS-1:0] MEDIUM_LEVEL_RST   = 23'd100;
    localparam logic [LEVEL_BITS-1:0] NEAR_LEVEL_RST     = 23'd1000;
    localparam logic [RUN_BITS-1:0]   DEBOUNCE_COUNT_RST = 8'd3;

    localparam logic [RUN_BITS-1:0] RUN_MAX = {RUN_BITS{1'b1}};

    localparam int OUT_FIELD_BITS = 2 + 2 + 1 + TIME_BITS;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

endpackage

// ----- rtl/proximity_zone_debouncer.sv -----
// Proximity zone debouncer: classifies delta samples and debounces zone changes.
//
//  channel   direction  handshake            content
//  s_*       in         s_tvalid / s_tready  delta_sample, time_ms
//  m_*       out        m_tvalid / m_tready  zone, last_zone, sar_active, entry_time
//  cfg_*     in         cfg_we               threshold, debounce and SAR registers
//
// One item per cycle sustained while m_tready stays high.
// Input register, then classification and counter update into the state,
// which doubles as the result register.
// A stalled result holds the input register; s_tready falls only when both are full.
// Reset (rst_n, async) returns zone state, counters and config registers to defaults.

`include "proximity_zone_debouncer_defines.svh"

module proximity_zone_debouncer
    import pzd_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
)
(
    input  logic clk,
    input  logic rst_n,

    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // delta_sample [SAMPLE_BITS-1:0], time_ms [SAMPLE_BITS+31:SAMPLE_BITS], zero pad
    input  logic [((SAMPLE_BITS+TIME_BITS+7)/8)*8-1:0]  s_tdata,

    output logic                      m_tvalid,
    input  logic                      m_tready,
    // zone [1:0], last_zone [3:2], sar_active [4], entry_time [36:5], zero pad
    output logic [OUT_DATA_BITS-1:0]  m_tdata,

    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [LEVEL_BITS-1:0]    cfg_data
);

    localparam int CMP_BITS = ((SAMPLE_BITS > LEVEL_BITS) ? SAMPLE_BITS : LEVEL_BITS) + 1;

    logic [LEVEL_BITS-1:0] far_level_reg;
    logic [LEVEL_BITS-1:0] medium_level_reg;
    logic [LEVEL_BITS-1:0] near_level_reg;
    logic [RUN_BITS-1:0]   debounce_reg;
    logic                  sar_enable_reg;

    logic                    s1_valid_reg;
    logic [SAMPLE_BITS-1:0]  s1_delta_reg;
    logic [TIME_BITS-1:0]    s1_time_reg;

    logic                    out_valid_reg;
    logic                    out_ready;
    logic                    adv;

    zone_t                   zone_reg, zone_next;
    zone_t                   last_zone_reg, last_zone_next;
    logic [RUN_BITS-1:0]     far_run_reg, far_run_next;
    logic [RUN_BITS-1:0]     close_run_reg, close_run_next;
    logic [TIME_BITS-1:0]    entry_time_reg, entry_time_next;
    logic                    sar_reg, sar_next;

    logic signed [CMP_BITS-1:0] delta_ext;
    logic signed [CMP_BITS-1:0] far_ext;
    logic signed [CMP_BITS-1:0] medium_ext;
    logic signed [CMP_BITS-1:0] near_ext;
    zone_t                      sample_zone;
    logic                       both_zero;
    logic [RUN_BITS-1:0]        run_base;
    logic [RUN_BITS-1:0]        run_new;
    logic                       zone_change;

    // handshake
    assign out_ready = !out_valid_reg || m_tready;
    assign adv       = s1_valid_reg && out_ready;
    assign s_tready  = !s1_valid_reg || out_ready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(OUT_DATA_BITS-OUT_FIELD_BITS){1'b0}},
                        entry_time_reg, sar_reg, last_zone_reg, zone_reg};

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            far_level_reg    <= FAR_LEVEL_RST;
            medium_level_reg <= MEDIUM_LEVEL_RST;
            near_level_reg   <= NEAR_LEVEL_RST;
            debounce_reg     <= DEBOUNCE_COUNT_RST;
            sar_enable_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FAR_LEVEL:      far_level_reg    <= cfg_data;
                CFG_MEDIUM_LEVEL:   medium_level_reg <= cfg_data;
                CFG_NEAR_LEVEL:     near_level_reg   <= cfg_data;
                CFG_DEBOUNCE_COUNT: debounce_reg     <= cfg_data[RUN_BITS-1:0];
                CFG_SAR_ENABLE:     sar_enable_reg   <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            s1_delta_reg <= s_tdata[SAMPLE_BITS-1:0];
            s1_time_reg  <= s_tdata[SAMPLE_BITS+TIME_BITS-1:SAMPLE_BITS];
        end
    end

    // classification, signed against zero-extended thresholds
    assign delta_ext  = {{(CMP_BITS-SAMPLE_BITS){s1_delta_reg[SAMPLE_BITS-1]}}, s1_delta_reg};
    assign far_ext    = {{(CMP_BITS-LEVEL_BITS){1'b0}}, far_level_reg};
    assign medium_ext = {{(CMP_BITS-LEVEL_BITS){1'b0}}, medium_level_reg};
    assign near_ext   = {{(CMP_BITS-LEVEL_BITS){1'b0}}, near_level_reg};

    always_comb
    begin
        if (delta_ext >= near_ext)
            sample_zone = ZONE_CONTACT;
        else if (delta_ext >= medium_ext)
            sample_zone = ZONE_NEAR;
        else if (delta_ext >= far_ext)
            sample_zone = ZONE_MEDIUM;
        else
            sample_zone = ZONE_FAR;
    end

    // run counters and zone update
    always_comb
    begin
        zone_next       = zone_reg;
        last_zone_next  = last_zone_reg;
        far_run_next    = far_run_reg;
        close_run_next  = close_run_reg;
        entry_time_next = entry_time_reg;
        sar_next        = sar_reg;
        both_zero       = (far_run_reg == '0) && (close_run_reg == '0);
        zone_change     = 1'b0;
        run_base        = '0;
        run_new         = '0;

        if (adv)
        begin
            if (sample_zone != zone_reg)
            begin
                if (sample_zone != ZONE_FAR)
                begin
                    // among close zones, a seed of one applies to near and contact only
                    if (both_zero && (sample_zone inside {ZONE_NEAR, ZONE_CONTACT}))
                        run_base = {{(RUN_BITS-1){1'b0}}, 1'b1};
                    else
                        run_base = close_run_reg;
                end
                else
                begin
                    if (both_zero)
                        run_base = {{(RUN_BITS-1){1'b0}}, 1'b1};
                    else
                        run_base = far_run_reg;
                end

                run_new     = (run_base == RUN_MAX) ? RUN_MAX : run_base + 1'b1;
                zone_change = (run_new >= debounce_reg);

                if (sample_zone != ZONE_FAR)
                begin
                    far_run_next   = '0;
                    close_run_next = zone_change ? '0 : run_new;
                end
                else
                begin
                    close_run_next = '0;
                    far_run_next   = zone_change ? '0 : run_new;
                end

                if (zone_change)
                begin
                    last_zone_next  = zone_reg;
                    zone_next       = sample_zone;
                    entry_time_next = s1_time_reg;
                end
            end
            else
            begin
                far_run_next   = '0;
                close_run_next = '0;
            end

            if (sar_enable_reg)
                sar_next = (zone_next != ZONE_FAR);
        end
    end

    // state, also the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            zone_reg       <= ZONE_FAR;
            last_zone_reg  <= ZONE_FAR;
            far_run_reg    <= '0;
            close_run_reg  <= '0;
            entry_time_reg <= '0;
            sar_reg        <= 1'b0;
        end
        else
        begin
            if (out_ready)
                out_valid_reg <= s1_valid_reg;
            zone_reg       <= zone_next;
            last_zone_reg  <= last_zone_next;
            far_run_reg    <= far_run_next;
            close_run_reg  <= close_run_next;
            entry_time_reg <= entry_time_next;
            sar_reg        <= sar_next;
        end
    end

    `PZD_ASSERT_SAME(a_runs_exclusive, 1'b1,
        (far_run_reg == '0) || (close_run_reg == '0), "both run counters nonzero")
    `PZD_ASSERT_NEXT(a_hold_when_stalled, !adv,
        $stable(zone_reg) && $stable(entry_time_reg) && $stable(far_run_reg),
        "state moved without an item")
    `PZD_ASSERT_NEXT(a_last_zone_tracks, adv && zone_change,
        (last_zone_reg == $past(zone_reg)) && (entry_time_reg == $past(s1_time_reg)),
        "zone change bookkeeping wrong")
    `PZD_ASSERT_NEXT(a_sar_follows_zone, adv && sar_enable_reg,
        sar_reg == (zone_reg != ZONE_FAR), "SAR flag does not follow zone")

endmodule
